@@ src/esc_pkg.sv @@
package esc_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_WRITE_DISABLE     = 3'd0,
    CFG_CLOCK_READY       = 3'd1,
    CFG_LOCAL_TIME_ENABLE = 3'd2,
    CFG_LOCAL_OFFSET      = 3'd3,
    CFG_YEAR_OFFSET       = 3'd4
  } cfg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 18;

  // register stages from input word to result word
  localparam int unsigned PIPE_DEPTH = 9;

  // last supported second, 2099-12-31 23:59:59
  localparam logic [31:0] MAX_COUNT = 32'd4102444799;

  // reciprocals, exact but for the day one, which may be one short
  localparam logic [24:0] DAY_RECIP  = 25'd25451658;  // 2^34 / 675
  localparam logic [12:0] HOUR_RECIP = 13'd4661;      // 2^20 / 225
  localparam logic [16:0] WEEK_RECIP = 17'd74899;     // 2^19 / 7
  localparam logic [12:0] MIN_RECIP  = 13'd4370;      // 2^16 / 15
  localparam logic [15:0] QUAD_RECIP = 16'd45934;     // 2^26 / 1461

  // days from 1968-01-01 to 1970-01-01
  localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } time_fields_t;

  typedef struct packed {
    logic [6:0] year_two_digit;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } date_fields_t;

  // first day of year of each month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] val;
    case (idx)
      4'd0:    val = 9'd0;
      4'd1:    val = 9'd31;
      4'd2:    val = 9'd59;
      4'd3:    val = 9'd90;
      4'd4:    val = 9'd120;
      4'd5:    val = 9'd151;
      4'd6:    val = 9'd181;
      4'd7:    val = 9'd212;
      4'd8:    val = 9'd243;
      4'd9:    val = 9'd273;
      4'd10:   val = 9'd304;
      4'd11:   val = 9'd334;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

@@ src/epoch_seconds_to_calendar.sv @@
// Converts seconds since 1970-01-01 into weekday, two-digit year, month, day,
// hour, minute and second for a real-time clock. The pipeline is nine register
// stages deep (the input stage plus eight stages of reciprocal multiplies and
// corrections): one word can enter every clock while the output is not
// stalled. A stall on the output holds the whole pipeline. In local-time mode
// the signed offset is subtracted first; in every mode the count is then
// clamped to 1970 .. end of 2099. When writing is disabled or the
// clock is not ready, every result comes out with tuser low and tdata zero.
// Configuration registers must only be written while the pipeline is empty.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] epoch_seconds
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [6:0] year_two_digit, [10:7] month,
                                   // [15:11] day_of_month, [20:16] hour,
                                   // [26:21] minute, [32:27] seconds_field,
                                   // [35:33] weekday, [39:36] zero
  output logic        out_tuser    // [0] written
);

  // configuration registers
  logic              write_disable_r;
  logic              clock_ready_r;
  logic              local_time_enable_r;
  logic signed [17:0] local_offset_r;
  logic [6:0]        year_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_disable_r     <= 1'b0;
      clock_ready_r       <= 1'b0;
      local_time_enable_r <= 1'b0;
      local_offset_r      <= '0;
      year_offset_r       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        esc_pkg::CFG_WRITE_DISABLE:     write_disable_r     <= cfg_wdata[0];
        esc_pkg::CFG_CLOCK_READY:       clock_ready_r       <= cfg_wdata[0];
        esc_pkg::CFG_LOCAL_TIME_ENABLE: local_time_enable_r <= cfg_wdata[0];
        esc_pkg::CFG_LOCAL_OFFSET:      local_offset_r      <= signed'(cfg_wdata);
        esc_pkg::CFG_YEAR_OFFSET:       year_offset_r       <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [esc_pkg::PIPE_DEPTH-1:0] valid_r;
  logic [esc_pkg::PIPE_DEPTH-1:0] wr_r;

  assign adv       = !valid_r[esc_pkg::PIPE_DEPTH-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[esc_pkg::PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_r <= {wr_r[esc_pkg::PIPE_DEPTH-2:0], !write_disable_r && clock_ready_r};
    end
  end

  // input stage: offset and clamp
  logic signed [33:0] adj_nxt;
  logic [31:0]        tm_nxt;
  logic [31:0]        tm_r;

  always_comb begin
    adj_nxt = signed'({2'b00, in_tdata})
              - (local_time_enable_r ? 34'(local_offset_r) : 34'sd0);
    if (adj_nxt[33]) begin
      tm_nxt = 32'd0;
    end else if (adj_nxt[32:0] > 33'(esc_pkg::MAX_COUNT)) begin
      tm_nxt = esc_pkg::MAX_COUNT;
    end else begin
      tm_nxt = adj_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm_r <= tm_nxt;
    end
  end

  logic [15:0]           days;
  esc_pkg::time_fields_t tfields;
  esc_pkg::date_fields_t dfields;

  esc_time_split u_time (
    .clk    (clk),
    .adv    (adv),
    .tm     (tm_r),
    .days   (days),
    .fields (tfields)
  );

  esc_date_split u_date (
    .clk         (clk),
    .adv         (adv),
    .days        (days),
    .year_offset (year_offset_r),
    .fields      (dfields)
  );

  logic wr_out;
  assign wr_out = wr_r[esc_pkg::PIPE_DEPTH-1];

  assign out_tvalid = valid_r[esc_pkg::PIPE_DEPTH-1];
  assign out_tuser  = wr_out;
  assign out_tdata  = wr_out ? {4'b0000, tfields.weekday, tfields.second, tfields.minute,
                                tfields.hour, dfields.day_of_month, dfields.month,
                                dfields.year_two_digit}
                             : 40'd0;

endmodule

@@ src/esc_time_split.sv @@
module esc_time_split (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [31:0]           tm,
  output logic [15:0]           days,
  output esc_pkg::time_fields_t fields
);

  // stage 1: seconds / 128 times reciprocal of 675
  logic [24:0] x1_r;
  logic [6:0]  lo1_r;
  logic [49:0] prod1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= tm[31:7];
      lo1_r   <= tm[6:0];
      prod1_r <= 50'(tm[31:7]) * 50'(esc_pkg::DAY_RECIP);
    end
  end

  // stage 2: estimated day count, may be one short
  logic [15:0] q2_nxt;
  logic [10:0] r2_nxt;
  logic [15:0] q2_r;
  logic [10:0] r2_r;
  logic [6:0]  lo2_r;

  always_comb begin
    q2_nxt = prod1_r[49:34];
    r2_nxt = 11'(26'(x1_r) - 26'(q2_nxt) * 26'd675);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_r  <= q2_nxt;
      r2_r  <= r2_nxt;
      lo2_r <= lo1_r;
    end
  end

  // stage 3: correct quotient, second of day
  logic        ge3;
  logic [10:0] rs3;
  logic [15:0] days3_nxt;
  logic [16:0] sod3_nxt;
  logic [15:0] days3_r;
  logic [16:0] sod3_r;

  always_comb begin
    ge3       = (r2_r >= 11'd675);
    rs3       = ge3 ? (r2_r - 11'd675) : r2_r;
    days3_nxt = q2_r + 16'(ge3);
    sod3_nxt  = {rs3[9:0], lo2_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      days3_r <= days3_nxt;
      sod3_r  <= sod3_nxt;
    end
  end

  assign days = days3_r;

  // stage 4: hour and weekday products
  logic [15:0] w4_nxt;
  logic [25:0] prodh4_r;
  logic [16:0] sod4_r;
  logic [15:0] w4_r;
  logic [32:0] prodw4_r;

  assign w4_nxt = days3_r + 16'd4;

  always_ff @(posedge clk) begin
    if (adv) begin
      prodh4_r <= 26'(sod3_r[16:4]) * 26'(esc_pkg::HOUR_RECIP);
      sod4_r   <= sod3_r;
      w4_r     <= w4_nxt;
      prodw4_r <= 33'(w4_nxt) * 33'(esc_pkg::WEEK_RECIP);
    end
  end

  // stage 5: hour, second of hour, weekday
  logic [4:0]  hour5_nxt;
  logic [11:0] remh5_nxt;
  logic [12:0] q7_5;
  logic [2:0]  wd5_nxt;
  logic [4:0]  hour5_r;
  logic [11:0] remh5_r;
  logic [2:0]  wd5_r;

  always_comb begin
    hour5_nxt = prodh4_r[24:20];
    remh5_nxt = 12'(sod4_r - 17'(hour5_nxt) * 17'd3600);
    q7_5      = prodw4_r[31:19];
    wd5_nxt   = 3'(w4_r - 16'(q7_5) * 16'd7);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hour5_r <= hour5_nxt;
      remh5_r <= remh5_nxt;
      wd5_r   <= wd5_nxt;
    end
  end

  // stage 6: minute product
  logic [22:0] prodm6_r;
  logic [11:0] remh6_r;
  logic [4:0]  hour6_r;
  logic [2:0]  wd6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prodm6_r <= 23'(remh5_r[11:2]) * 23'(esc_pkg::MIN_RECIP);
      remh6_r  <= remh5_r;
      hour6_r  <= hour5_r;
      wd6_r    <= wd5_r;
    end
  end

  // stage 7: minute and second
  logic [5:0] min7_nxt;
  logic [5:0] sec7_nxt;
  logic [5:0] min7_r;
  logic [5:0] sec7_r;
  logic [4:0] hour7_r;
  logic [2:0] wd7_r;

  always_comb begin
    min7_nxt = prodm6_r[21:16];
    sec7_nxt = 6'(remh6_r - 12'(min7_nxt) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      min7_r  <= min7_nxt;
      sec7_r  <= sec7_nxt;
      hour7_r <= hour6_r;
      wd7_r   <= wd6_r;
    end
  end

  // stage 8: line up with the date path
  esc_pkg::time_fields_t fields8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fields8_r.hour    <= hour7_r;
      fields8_r.minute  <= min7_r;
      fields8_r.second  <= sec7_r;
      fields8_r.weekday <= wd7_r;
    end
  end

  assign fields = fields8_r;

endmodule

@@ src/esc_date_split.sv @@
module esc_date_split (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [15:0]           days,
  input  logic [6:0]            year_offset,
  output esc_pkg::date_fields_t fields
);

  // stage 4: days since 1968, start of a four-year cycle
  logic [15:0] d4_nxt;
  logic [15:0] d4_r;
  logic [31:0] prodq4_r;

  assign d4_nxt = days + esc_pkg::DAYS_1968_TO_1970;

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_r     <= d4_nxt;
      prodq4_r <= 32'(d4_nxt) * 32'(esc_pkg::QUAD_RECIP);
    end
  end

  // stage 5: cycle number and day within cycle
  logic [5:0]  quad5_nxt;
  logic [10:0] r5_nxt;
  logic [5:0]  quad5_r;
  logic [10:0] r5_r;

  always_comb begin
    quad5_nxt = prodq4_r[31:26];
    r5_nxt    = 11'(d4_r - 16'(quad5_nxt) * 16'd1461);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quad5_r <= quad5_nxt;
      r5_r    <= r5_nxt;
    end
  end

  // stage 6: year and day of year, first year of each cycle is leap
  logic [10:0] rr6;
  logic [1:0]  yq6;
  logic [10:0] doy6_full;
  logic [7:0]  year6_nxt;
  logic [7:0]  year6_r;
  logic [8:0]  doy6_r;
  logic        leap6_r;

  always_comb begin
    rr6 = r5_r - 11'd366;
    if (r5_r < 11'd366) begin
      yq6       = 2'd0;
      doy6_full = r5_r;
    end else if (rr6 >= 11'd730) begin
      yq6       = 2'd3;
      doy6_full = rr6 - 11'd730;
    end else if (rr6 >= 11'd365) begin
      yq6       = 2'd2;
      doy6_full = rr6 - 11'd365;
    end else begin
      yq6       = 2'd1;
      doy6_full = rr6;
    end
    year6_nxt = 8'd68 + {quad5_r, 2'b00} + 8'(yq6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      year6_r <= year6_nxt;
      doy6_r  <= doy6_full[8:0];
      leap6_r <= (yq6 == 2'd0);
    end
  end

  // stage 7: month scan against all bounds at once, two-digit year
  logic [3:0] cnt7_nxt;
  logic [9:0] bound7;
  logic [8:0] yv7;
  logic [6:0] yy7_nxt;
  logic [3:0] cnt7_r;
  logic [8:0] doy7_r;
  logic       leap7_r;
  logic [6:0] yy7_r;

  always_comb begin
    cnt7_nxt = 4'd0;
    bound7   = 10'd0;
    for (int m = 1; m < 12; m++) begin
      bound7   = 10'(esc_pkg::month_start(4'(m))) + 10'(leap6_r && (m > 1));
      cnt7_nxt = cnt7_nxt + 4'(10'(doy6_r) >= bound7);
    end
    yv7 = 9'(year6_r) + 9'd200 - 9'(year_offset);
    if (yv7 >= 9'd300) begin
      yy7_nxt = 7'(yv7 - 9'd300);
    end else if (yv7 >= 9'd200) begin
      yy7_nxt = 7'(yv7 - 9'd200);
    end else if (yv7 >= 9'd100) begin
      yy7_nxt = 7'(yv7 - 9'd100);
    end else begin
      yy7_nxt = 7'(yv7);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt7_r  <= cnt7_nxt;
      doy7_r  <= doy6_r;
      leap7_r <= leap6_r;
      yy7_r   <= yy7_nxt;
    end
  end

  // stage 8: day of month
  logic [8:0] day8_nxt;
  esc_pkg::date_fields_t fields8_r;

  assign day8_nxt = doy7_r - esc_pkg::month_start(cnt7_r) + 9'd1
                    - 9'(leap7_r && (cnt7_r >= 4'd2));

  always_ff @(posedge clk) begin
    if (adv) begin
      fields8_r.year_two_digit <= yy7_r;
      fields8_r.month          <= cnt7_r + 4'd1;
      fields8_r.day_of_month   <= day8_nxt[4:0];
    end
  end

  assign fields = fields8_r;

endmodule
